// ===== rtl/rme_pkg.sv =====
// Shared types, codes and helpers of the register machine execute unit.
// Depends on nothing; every other file refers to it by scoped names.
package rme_pkg;

	localparam int MEM_BYTES = 256;
	localparam int NUM_REGS  = 8;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int REG_AW    = $clog2(NUM_REGS);

	// Instruction codes
	localparam logic [3:0] ACT_STORE   = 4'd1;
	localparam logic [3:0] ACT_LOAD    = 4'd2;
	localparam logic [3:0] ACT_ADD     = 4'd3;
	localparam logic [3:0] ACT_SUB     = 4'd4;
	localparam logic [3:0] ACT_MUL     = 4'd5;
	localparam logic [3:0] ACT_READ    = 4'd6;
	localparam logic [3:0] ACT_PRINT   = 4'd7;
	localparam logic [3:0] ACT_BRANCH  = 4'd8;
	localparam logic [3:0] ACT_JUMP    = 4'd14;
	localparam logic [3:0] ACT_PRELOAD = 4'd15;

	// Comparison codes of the conditional branch
	localparam logic [7:0] CMP_EQ = 8'd9;
	localparam logic [7:0] CMP_GT = 8'd10;
	localparam logic [7:0] CMP_LT = 8'd11;
	localparam logic [7:0] CMP_GE = 8'd12;
	localparam logic [7:0] CMP_LE = 8'd13;

	typedef struct packed {
		logic        [3:0] action;
		logic        [7:0] first_operand;
		logic        [7:0] second_operand;
		logic        [7:0] third_operand;
		logic        [7:0] fourth_operand;
		logic signed [31:0] entered_value;
	} in_item_t;

	typedef struct packed {
		logic               shown_valid;
		logic        [2:0]  shown_register;
		logic signed [31:0] shown_value;
		logic               jump_taken;
		logic        [7:0]  jump_line;
	} out_item_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] idx;
		logic [31:0]       data;
	} reg_wr_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	// Register read port A: compared or printed register, else first source
	function automatic logic [REG_AW-1:0] reg_a_idx(in_item_t it);
		logic [REG_AW-1:0] idx;
		if (it.action == ACT_BRANCH || it.action == ACT_PRINT) begin
			idx = it.first_operand[REG_AW-1:0];
		end else begin
			idx = it.second_operand[REG_AW-1:0];
		end
		return idx;
	endfunction

	// Register read port B: second compared register, else second source
	function automatic logic [REG_AW-1:0] reg_b_idx(in_item_t it);
		logic [REG_AW-1:0] idx;
		if (it.action == ACT_BRANCH) begin
			idx = it.second_operand[REG_AW-1:0];
		end else begin
			idx = it.third_operand[REG_AW-1:0];
		end
		return idx;
	endfunction

	// Memory index from a byte operand, widened or narrowed to the depth
	function automatic logic [MEM_AW-1:0] mem_index(logic [7:0] op);
		logic [MEM_AW+7:0] ext;
		ext = {{MEM_AW{1'b0}}, op};
		return ext[MEM_AW-1:0];
	endfunction

	function automatic logic mem_in_range(logic [7:0] op);
		logic [MEM_AW+7:0] ext;
		ext = {{MEM_AW{1'b0}}, op};
		return ext < (MEM_AW+8)'(MEM_BYTES);
	endfunction

endpackage

// ===== rtl/rme_in_if.sv =====
// Instruction channel: valid/ready handshake carrying one instruction item.
// Depends on rme_pkg for the payload type.
interface rme_in_if;
	logic              valid;
	logic              ready;
	rme_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rme_out_if.sv =====
// Result channel: valid/ready handshake carrying one result item.
// Depends on rme_pkg for the payload type.
interface rme_out_if;
	logic               valid;
	logic               ready;
	rme_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rme_regfile.sv =====
// Register file: eight 32-bit registers, two registered read ports, one write.
// Depends on rme_pkg.
module rme_regfile (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [rme_pkg::REG_AW-1:0]  ra,
	input  logic [rme_pkg::REG_AW-1:0]  rb,
	input  rme_pkg::reg_wr_t            wr,
	output logic [31:0]                 rda,
	output logic [31:0]                 rdb
);

	logic [31:0] regs_q [rme_pkg::NUM_REGS];
	logic [31:0] rda_q;
	logic [31:0] rdb_q;

	// Write one register per cycle; clear all at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rme_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr.en) begin
			regs_q[wr.idx] <= wr.data;
		end
	end

	// Capture both read ports when an item enters; old data on a same-edge write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rda_q <= regs_q[ra];
			rdb_q <= regs_q[rb];
		end
	end

	assign rda = rda_q;
	assign rdb = rdb_q;

endmodule

// ===== rtl/rme_dmem.sv =====
// Byte data memory with one registered read port, one write port and a
// zero-fill sweep after reset. Depends on rme_pkg.
module rme_dmem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [rme_pkg::MEM_AW-1:0]  ra,
	input  rme_pkg::mem_wr_t            wr,
	output logic [7:0]                  rd,
	output logic                        busy
);

	logic [7:0]                mem [rme_pkg::MEM_BYTES];
	logic [7:0]                rd_q;
	logic [rme_pkg::MEM_AW:0]  clr_cnt_q;

	assign busy = clr_cnt_q != (rme_pkg::MEM_AW+1)'(rme_pkg::MEM_BYTES);

	// Advance the clear sweep one byte per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Write zero during the sweep, else the committed store
	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_cnt_q[rme_pkg::MEM_AW-1:0]] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read when an item enters
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

// ===== rtl/rme_exec.sv =====
// Execute logic: forwarding, ALU, compare and result forming for the item
// held in the input stage. Depends on rme_pkg.
module rme_exec (
	input  rme_pkg::in_item_t   item,
	input  logic [31:0]         rda,
	input  logic [31:0]         rdb,
	input  logic [7:0]          mrd,
	input  rme_pkg::reg_wr_t    rfwd,
	input  rme_pkg::mem_wr_t    mfwd,
	output rme_pkg::reg_wr_t    reg_wr,
	output rme_pkg::mem_wr_t    mem_wr,
	output rme_pkg::out_item_t  res
);

	logic [31:0]        va;
	logic [31:0]        vb;
	logic [7:0]         vm;
	logic               cond;
	logic [rme_pkg::REG_AW-1:0] a_idx;
	logic [rme_pkg::REG_AW-1:0] b_idx;
	logic [rme_pkg::MEM_AW-1:0] ld_addr;

	assign a_idx   = rme_pkg::reg_a_idx(item);
	assign b_idx   = rme_pkg::reg_b_idx(item);
	assign ld_addr = rme_pkg::mem_index(item.second_operand);

	// Forward the write that committed as this item was read
	always_comb begin
		va = (rfwd.en && rfwd.idx == a_idx) ? rfwd.data : rda;
		vb = (rfwd.en && rfwd.idx == b_idx) ? rfwd.data : rdb;
		vm = (mfwd.en && mfwd.addr == ld_addr) ? mfwd.data : mrd;
	end

	// Signed comparison; an unknown code counts as false
	always_comb begin
		case (item.third_operand)
			rme_pkg::CMP_EQ: cond = va == vb;
			rme_pkg::CMP_GT: cond = $signed(va) >  $signed(vb);
			rme_pkg::CMP_LT: cond = $signed(va) <  $signed(vb);
			rme_pkg::CMP_GE: cond = $signed(va) >= $signed(vb);
			rme_pkg::CMP_LE: cond = $signed(va) <= $signed(vb);
			default:         cond = 1'b0;
		endcase
	end

	// Decode the action into writes and a result
	always_comb begin
		reg_wr      = '0;
		reg_wr.idx  = item.first_operand[rme_pkg::REG_AW-1:0];
		mem_wr      = '0;
		mem_wr.addr = rme_pkg::mem_index(item.first_operand);
		res         = '0;
		unique case (item.action)
			rme_pkg::ACT_STORE: begin
				mem_wr.en   = rme_pkg::mem_in_range(item.first_operand);
				mem_wr.data = va[7:0];
			end
			rme_pkg::ACT_LOAD: begin
				reg_wr.en = 1'b1;
				if (rme_pkg::mem_in_range(item.second_operand)) begin
					reg_wr.data = {{24{vm[7]}}, vm};
				end
			end
			rme_pkg::ACT_ADD: begin
				reg_wr.en   = 1'b1;
				reg_wr.data = va + vb;
			end
			rme_pkg::ACT_SUB: begin
				reg_wr.en   = 1'b1;
				reg_wr.data = va - vb;
			end
			rme_pkg::ACT_MUL: begin
				reg_wr.en   = 1'b1;
				reg_wr.data = va * vb;
			end
			rme_pkg::ACT_READ: begin
				reg_wr.en   = 1'b1;
				reg_wr.data = item.entered_value;
			end
			rme_pkg::ACT_PRINT: begin
				res.shown_valid    = 1'b1;
				res.shown_register = item.first_operand[2:0];
				res.shown_value    = va;
			end
			rme_pkg::ACT_BRANCH: begin
				if (!cond) begin
					res.jump_taken = 1'b1;
					res.jump_line  = item.fourth_operand;
				end
			end
			rme_pkg::ACT_JUMP: begin
				res.jump_taken = 1'b1;
				res.jump_line  = item.first_operand;
			end
			rme_pkg::ACT_PRELOAD: begin
				mem_wr.en   = rme_pkg::mem_in_range(item.first_operand);
				mem_wr.data = item.entered_value[7:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/register_machine_execute_unit.sv =====
// Top level of the register machine execute unit: input stage, execute,
// result register. Depends on rme_pkg, rme_in_if, rme_out_if and submodules.
//
//   port    dir   moves
//   instr   in    one instruction item per handshake
//   result  out   one result item per instruction
//
// One instruction per cycle sustained while results are taken; each item
// passes through the input stage (register and memory reads land there) and
// then sits in the result register. Writes commit as the item leaves the
// input stage; the next item's reads are patched by forwarding. After reset
// the MEM_BYTES-byte memory is zeroed with instr.ready low. A stalled result
// holds the input stage, and the input stage holds instr.ready low.
module register_machine_execute_unit (
	input  logic       clk,
	input  logic       arst_n,
	rme_in_if.sink     instr,
	rme_out_if.source  result
);

	logic               s1_valid_q;
	rme_pkg::in_item_t  item_s1;
	rme_pkg::reg_wr_t   rfwd_q;
	rme_pkg::mem_wr_t   mfwd_q;
	logic               out_valid_q;
	rme_pkg::out_item_t out_q;

	logic               accept;
	logic               s1_adv;
	logic               commit;
	logic               mem_busy;
	logic [31:0]        rda;
	logic [31:0]        rdb;
	logic [7:0]         mrd;
	rme_pkg::reg_wr_t   reg_wr;
	rme_pkg::mem_wr_t   mem_wr;
	rme_pkg::reg_wr_t   reg_wr_c;
	rme_pkg::mem_wr_t   mem_wr_c;
	rme_pkg::out_item_t res;

	// Handshake control
	assign s1_adv      = s1_valid_q && (!out_valid_q || result.ready);
	assign commit      = s1_adv;
	assign instr.ready = !mem_busy && (!s1_valid_q || s1_adv);
	assign accept      = instr.valid && instr.ready;

	// Gate writes to the edge at which the item leaves the input stage
	always_comb begin
		reg_wr_c    = reg_wr;
		mem_wr_c    = mem_wr;
		reg_wr_c.en = reg_wr.en && commit;
		mem_wr_c.en = mem_wr.en && commit;
	end

	rme_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra     (rme_pkg::reg_a_idx(instr.data)),
		.rb     (rme_pkg::reg_b_idx(instr.data)),
		.wr     (reg_wr_c),
		.rda    (rda),
		.rdb    (rdb)
	);

	rme_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra     (rme_pkg::mem_index(instr.data.second_operand)),
		.wr     (mem_wr_c),
		.rd     (mrd),
		.busy   (mem_busy)
	);

	rme_exec u_exec (
		.item   (item_s1),
		.rda    (rda),
		.rdb    (rdb),
		.mrd    (mrd),
		.rfwd   (rfwd_q),
		.mfwd   (mfwd_q),
		.reg_wr (reg_wr),
		.mem_wr (mem_wr),
		.res    (res)
	);

	// Input stage valid and forwarding record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rfwd_q     <= '0;
			mfwd_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				rfwd_q     <= reg_wr_c;
				mfwd_q     <= mem_wr_c;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= instr.data;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule
